// File: sv/c2p_pkg.sv
// ----------------------------------------------------------------------------
// c2p_pkg
// Shared types, constants and tables for the Cartesian to polar radar block.
// ----------------------------------------------------------------------------
package c2p_pkg;

    // Word format of the tracked state
    localparam int WORD_WIDTH   = 32;
    localparam int FRAC_BITS    = 16;

    // Pipeline depths of the cell rows
    localparam int CORDIC_STEPS = 24;
    localparam int ROOT_STEPS   = 32;
    localparam int DIV_STEPS    = 32;

    // CORDIC working formats
    localparam int XY_W         = 44;
    localparam int Z_W          = 36;
    localparam int NORM_MSB     = 40;

    localparam logic signed [Z_W-1:0] PI_Q32      = 36'sd13493037704;
    localparam logic signed [18:0]    BEARING_LIM = 19'sd205887;
    localparam logic [31:0]           RATE_LIMIT  = 32'd3037000500;

    // Configuration register file
    localparam int          ADDR_W          = 3;
    localparam logic        REG_MIN_RANGE   = 1'b0;
    localparam logic [15:0] MIN_RANGE_RESET = 16'd7;

    // arctan(2^-k) in Q32 radians
    function automatic logic signed [Z_W-1:0] atan_q32(input logic [4:0] k);
        logic signed [Z_W-1:0] v;
        case (k)
            5'd0:    v = 36'sd3373259426;
            5'd1:    v = 36'sd1991351318;
            5'd2:    v = 36'sd1052175346;
            5'd3:    v = 36'sd534100635;
            5'd4:    v = 36'sd268086748;
            5'd5:    v = 36'sd134174063;
            5'd6:    v = 36'sd67103404;
            5'd7:    v = 36'sd33553749;
            5'd8:    v = 36'sd16777131;
            5'd9:    v = 36'sd8388597;
            5'd10:   v = 36'sd4194303;
            5'd11:   v = 36'sd2097152;
            5'd12:   v = 36'sd1048576;
            5'd13:   v = 36'sd524288;
            5'd14:   v = 36'sd262144;
            5'd15:   v = 36'sd131072;
            5'd16:   v = 36'sd65536;
            5'd17:   v = 36'sd32768;
            5'd18:   v = 36'sd16384;
            5'd19:   v = 36'sd8192;
            5'd20:   v = 36'sd4096;
            5'd21:   v = 36'sd2048;
            5'd22:   v = 36'sd1024;
            5'd23:   v = 36'sd512;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Square root and CORDIC row payload
    typedef struct packed {
        logic                  valid;
        logic [63:0]           n;
        logic [63:0]           r;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0] z;
        logic                  zero;
        logic [63:0]           dmag;
        logic                  neg;
    } t_root;

    // Divider row payload
    typedef struct packed {
        logic        valid;
        logic [31:0] rem;
        logic [31:0] dlo;
        logic [31:0] q;
        logic [31:0] div;
        logic        ovf;
        logic        dz;
        logic        neg;
        logic [31:0] range;
        logic [18:0] bearing;
    } t_div;

endpackage

// File: sv/c2p_if.sv
// ----------------------------------------------------------------------------
// c2p_in_if / c2p_out_if
// Valid/ready channels carrying the state vector and the radar prediction.
// ----------------------------------------------------------------------------
interface c2p_in_if import c2p_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [WORD_WIDTH-1:0] pos_x;
    logic signed [WORD_WIDTH-1:0] pos_y;
    logic signed [WORD_WIDTH-1:0] vel_x;
    logic signed [WORD_WIDTH-1:0] vel_y;

    modport source (output valid, pos_x, pos_y, vel_x, vel_y, input ready);
    modport sink   (input valid, pos_x, pos_y, vel_x, vel_y, output ready);
endinterface

interface c2p_out_if;
    logic               valid;
    logic               ready;
    logic [31:0]        range_out;
    logic signed [18:0] bearing;
    logic signed [32:0] range_rate;

    modport source (output valid, range_out, bearing, range_rate, input ready);
    modport sink   (input valid, range_out, bearing, range_rate, output ready);
endinterface

// File: sv/c2p_front.sv
// ----------------------------------------------------------------------------
// c2p_front
// Two input stages: products, CORDIC pre-rotation and normalization, then
// sum of squares and signed dot-product magnitude.
// ----------------------------------------------------------------------------
module c2p_front import c2p_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic signed [WORD_WIDTH-1:0] i_px,
    input  logic signed [WORD_WIDTH-1:0] i_py,
    input  logic signed [WORD_WIDTH-1:0] i_vx,
    input  logic signed [WORD_WIDTH-1:0] i_vy,
    output t_root                        o_q
);
    logic [31:0]            apx, apy, avx, avy, m;
    logic signed [32:0]     x33, y33, ay;
    logic signed [Z_W-1:0]  z0;
    logic [4:0]             msb;
    logic [5:0]             sh;

    logic                   r_v1, r_n1, r_n2, r_zero;
    logic [63:0]            r_sx, r_sy, r_t1, r_t2;
    logic signed [XY_W-1:0] r_x, r_y;
    logic signed [Z_W-1:0]  r_z;
    t_root                  r_q, n_q;

    // magnitudes and CORDIC pre-rotation into the right half plane
    always_comb begin
        apx = i_px[31] ? 32'(~i_px + 32'sd1) : 32'(i_px);
        apy = i_py[31] ? 32'(~i_py + 32'sd1) : 32'(i_py);
        avx = i_vx[31] ? 32'(~i_vx + 32'sd1) : 32'(i_vx);
        avy = i_vy[31] ? 32'(~i_vy + 32'sd1) : 32'(i_vy);
        x33 = 33'(i_px);
        y33 = 33'(i_py);
        z0  = '0;
        if (i_px[31]) begin
            z0  = i_py[31] ? -PI_Q32 : PI_Q32;
            x33 = -x33;
            y33 = -y33;
        end
        ay  = y33[32] ? -y33 : y33;
        m   = (x33 > ay) ? x33[31:0] : ay[31:0];
        msb = '0;
        for (int i = 0; i < 32; i++) begin
            if (m[i]) msb = 5'(i);
        end
        sh  = 6'(NORM_MSB) - 6'(msb);
    end

    // stage 1: products and normalized vector
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
        if (i_en) begin
            r_sx   <= apx * apx;
            r_sy   <= apy * apy;
            r_t1   <= apx * avx;
            r_t2   <= apy * avy;
            r_n1   <= i_px[31] ^ i_vx[31];
            r_n2   <= i_py[31] ^ i_vy[31];
            r_x    <= XY_W'(x33) <<< sh;
            r_y    <= XY_W'(y33) <<< sh;
            r_z    <= z0;
            r_zero <= (i_px == '0) && (i_py == '0);
        end
    end

    // stage 2: sum of squares and dot-product sign/magnitude
    always_comb begin
        n_q       = '0;
        n_q.valid = r_v1;
        n_q.n     = r_sx + r_sy;
        n_q.r     = '0;
        n_q.x     = r_x;
        n_q.y     = r_y;
        n_q.z     = r_z;
        n_q.zero  = r_zero;
        if (r_n1 == r_n2) begin
            n_q.dmag = r_t1 + r_t2;
            n_q.neg  = r_n1;
        end else if (r_t1 >= r_t2) begin
            n_q.dmag = r_t1 - r_t2;
            n_q.neg  = r_n1;
        end else begin
            n_q.dmag = r_t2 - r_t1;
            n_q.neg  = r_n2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.valid <= 1'b0;
        end else if (i_en) begin
            r_q.valid <= n_q.valid;
        end
        if (i_en) begin
            r_q.n    <= n_q.n;
            r_q.r    <= n_q.r;
            r_q.x    <= n_q.x;
            r_q.y    <= n_q.y;
            r_q.z    <= n_q.z;
            r_q.zero <= n_q.zero;
            r_q.dmag <= n_q.dmag;
            r_q.neg  <= n_q.neg;
        end
    end

    assign o_q = r_q;

endmodule

// File: sv/c2p_root_cell.sv
// ----------------------------------------------------------------------------
// c2p_root_cell
// One step of the digit-by-digit square root and, for the first steps,
// one CORDIC vectoring rotation.
// ----------------------------------------------------------------------------
module c2p_root_cell import c2p_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [4:0] i_step,
    input  t_root      i_d,
    output t_root      o_q
);
    logic [63:0]            bit_w, trial;
    logic signed [XY_W-1:0] xs, ys;
    t_root                  n_q, r_q;

    always_comb begin
        n_q   = i_d;
        bit_w = 64'd1 << (6'd62 - {i_step, 1'b0});
        trial = i_d.r + bit_w;
        // square root digit
        if (i_d.n >= trial) begin
            n_q.n = i_d.n - trial;
            n_q.r = (i_d.r >> 1) + bit_w;
        end else begin
            n_q.r = i_d.r >> 1;
        end
        // CORDIC rotation toward the x axis
        xs = i_d.x >>> i_step;
        ys = i_d.y >>> i_step;
        if (i_step < 5'(CORDIC_STEPS)) begin
            if (!i_d.y[XY_W-1]) begin
                n_q.x = i_d.x + ys;
                n_q.y = i_d.y - xs;
                n_q.z = i_d.z + atan_q32(i_step);
            end else begin
                n_q.x = i_d.x - ys;
                n_q.y = i_d.y + xs;
                n_q.z = i_d.z - atan_q32(i_step);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.valid <= 1'b0;
        end else if (i_en) begin
            r_q.valid <= n_q.valid;
        end
        if (i_en) begin
            r_q.n    <= n_q.n;
            r_q.r    <= n_q.r;
            r_q.x    <= n_q.x;
            r_q.y    <= n_q.y;
            r_q.z    <= n_q.z;
            r_q.zero <= n_q.zero;
            r_q.dmag <= n_q.dmag;
            r_q.neg  <= n_q.neg;
        end
    end

    assign o_q = r_q;

endmodule

// File: sv/c2p_div_cell.sv
// ----------------------------------------------------------------------------
// c2p_div_cell
// One restoring division step: one quotient bit of the range rate.
// ----------------------------------------------------------------------------
module c2p_div_cell import c2p_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_div  i_d,
    output t_div  o_q
);
    logic [32:0] rem2;
    t_div        n_q, r_q;

    always_comb begin
        n_q   = i_d;
        rem2  = {i_d.rem, i_d.dlo[31]};
        n_q.dlo = {i_d.dlo[30:0], 1'b0};
        if (rem2 >= {1'b0, i_d.div}) begin
            n_q.rem = 32'(rem2 - {1'b0, i_d.div});
            n_q.q   = {i_d.q[30:0], 1'b1};
        end else begin
            n_q.rem = rem2[31:0];
            n_q.q   = {i_d.q[30:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.valid <= 1'b0;
        end else if (i_en) begin
            r_q.valid <= n_q.valid;
        end
        if (i_en) begin
            r_q.rem     <= n_q.rem;
            r_q.dlo     <= n_q.dlo;
            r_q.q       <= n_q.q;
            r_q.div     <= n_q.div;
            r_q.ovf     <= n_q.ovf;
            r_q.dz      <= n_q.dz;
            r_q.neg     <= n_q.neg;
            r_q.range   <= n_q.range;
            r_q.bearing <= n_q.bearing;
        end
    end

    assign o_q = r_q;

endmodule

// File: sv/cartesian_to_polar_radar_top.sv
// ----------------------------------------------------------------------------
// cartesian_to_polar_radar_top
// Radar measurement prediction: range, bearing and range rate from a
// Cartesian position/velocity state.
// ----------------------------------------------------------------------------
// The block takes one state vector per clock and returns one result per
// vector, in order: two input stages, a row of 32 square-root cells (the
// first 24 also run the CORDIC bearing rotation), one divisor-select stage,
// a row of 32 divider cells and the output register. All rows advance
// together and stall only while the output register holds an untaken
// result. The user must write min_range through the APB port at address 0
// only while no transaction is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module cartesian_to_polar_radar_top import c2p_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    c2p_in_if.sink            i_in,
    c2p_out_if.source         o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    logic        en;
    logic [15:0] r_min_range;
    t_root       w_root [0:ROOT_STEPS];
    t_div        w_div  [0:DIV_STEPS];
    t_div        n_mid, r_mid;

    logic [31:0]           range, div, qf;
    logic signed [Z_W-1:0] zr;
    logic signed [18:0]    b;
    logic                  r_out_valid;
    logic [31:0]           r_range;
    logic signed [18:0]    r_bearing;
    logic signed [32:0]    r_rate, n_rate;

    // global advance of the cell rows
    assign en         = !r_out_valid || o_out.ready;
    assign i_in.ready = en;

    // configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MIN_RANGE) ? {16'd0, r_min_range} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_range <= MIN_RANGE_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_MIN_RANGE) begin
            r_min_range <= pwdata[15:0];
        end
    end

    c2p_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in.valid),
        .i_px    (i_in.pos_x),
        .i_py    (i_in.pos_y),
        .i_vx    (i_in.vel_x),
        .i_vy    (i_in.vel_y),
        .o_q     (w_root[0])
    );

    // square root and CORDIC row
    for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
        c2p_root_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_step  (5'(k)),
            .i_d     (w_root[k]),
            .o_q     (w_root[k+1])
        );
    end

    // divisor select, overflow check, bearing rounding and clamp
    always_comb begin
        range = w_root[ROOT_STEPS].r[31:0];
        div   = (range <= {16'd0, r_min_range}) ? {16'd0, r_min_range} : range;
        zr    = (w_root[ROOT_STEPS].z + (Z_W'(1) <<< (31 - FRAC_BITS))) >>>
                (32 - FRAC_BITS);
        if (w_root[ROOT_STEPS].zero) begin
            b = '0;
        end else if (zr > Z_W'(BEARING_LIM)) begin
            b = BEARING_LIM;
        end else if (zr < -Z_W'(BEARING_LIM)) begin
            b = -BEARING_LIM;
        end else begin
            b = zr[18:0];
        end
        n_mid         = '0;
        n_mid.valid   = w_root[ROOT_STEPS].valid;
        n_mid.rem     = w_root[ROOT_STEPS].dmag[63:32];
        n_mid.dlo     = w_root[ROOT_STEPS].dmag[31:0];
        n_mid.div     = div;
        n_mid.ovf     = w_root[ROOT_STEPS].dmag[63:32] >= div;
        n_mid.dz      = (div == '0);
        n_mid.neg     = w_root[ROOT_STEPS].neg;
        n_mid.range   = range;
        n_mid.bearing = b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid.valid <= 1'b0;
        end else if (en) begin
            r_mid.valid <= n_mid.valid;
        end
        if (en) begin
            r_mid.rem     <= n_mid.rem;
            r_mid.dlo     <= n_mid.dlo;
            r_mid.q       <= n_mid.q;
            r_mid.div     <= n_mid.div;
            r_mid.ovf     <= n_mid.ovf;
            r_mid.dz      <= n_mid.dz;
            r_mid.neg     <= n_mid.neg;
            r_mid.range   <= n_mid.range;
            r_mid.bearing <= n_mid.bearing;
        end
    end

    assign w_div[0] = r_mid;

    // divider row
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        c2p_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_d     (w_div[k]),
            .o_q     (w_div[k+1])
        );
    end

    // saturation and sign of the range rate
    always_comb begin
        if (w_div[DIV_STEPS].dz) begin
            qf = '0;
        end else if (w_div[DIV_STEPS].ovf || w_div[DIV_STEPS].q > RATE_LIMIT) begin
            qf = RATE_LIMIT;
        end else begin
            qf = w_div[DIV_STEPS].q;
        end
        n_rate = w_div[DIV_STEPS].neg ? -$signed({1'b0, qf}) : $signed({1'b0, qf});
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= w_div[DIV_STEPS].valid;
        end
        if (en) begin
            r_range   <= w_div[DIV_STEPS].range;
            r_bearing <= w_div[DIV_STEPS].bearing;
            r_rate    <= n_rate;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.range_out  = r_range;
    assign o_out.bearing    = r_bearing;
    assign o_out.range_rate = r_rate;

endmodule
